/* design/rmq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int TW    = 18;  // t width, signed
    localparam int RW    = 17;  // root width: sqrt(t*2^16) < 2^17
    localparam int RADW  = 34;  // radicand width
    localparam int DW    = 17;  // off-diagonal difference width
    localparam int NUMW  = 31;  // |d| << 14 plus rounding term
    localparam int QW    = 31;  // quotient width

    localparam logic signed [TW-1:0] ONE_Q14 = 18'sd16384;

    typedef logic signed [15:0] q14_t;

    typedef struct packed {
        q14_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
    } matrix_t;

    typedef struct packed {
        q14_t quat_w, quat_x, quat_y, quat_z;
        logic bad_input;
    } quat_t;

    // Branch select: which quaternion component (w,x,y,z) is taken from the square root.
    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } branch_t;

    // Front end result handed to the root and divide pipelines.
    typedef struct packed {
        branch_t                  br;
        logic                     bad;
        logic        [TW-2:0]     t;
        logic signed [DW-1:0]     d1, d2, d3;
    } front_t;

    function automatic q14_t sat16(input logic signed [QW:0] v);
        if (v > 32'sd32767)
            return 16'sh7fff;
        else if (v < -32'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

endpackage

/* design/rmq_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_stream_if
// Valid/ready channel carrying a payload of parameterized type.
// ----------------------------------------------------------------------------
interface rmq_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/rmq_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_front
// Branch select, t and the three off-diagonal differences. Two stages.
// ----------------------------------------------------------------------------
module rmq_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  rmq_pkg::matrix_t  in_data,
    output logic              out_valid,
    output rmq_pkg::front_t   out_data
);
    import rmq_pkg::*;

    logic    valid_a_reg;
    branch_t br_a_reg;
    matrix_t m_a_reg;

    logic signed [17:0] tr;
    branch_t            br_next;

    assign tr = 18'(in_data.m00) + 18'(in_data.m11) + 18'(in_data.m22);

    always_comb
    begin
        priority if (tr > 18'sd0)
            br_next = BR_TRACE;
        else if (in_data.m00 > in_data.m11 && in_data.m00 > in_data.m22)
            br_next = BR_X;
        else if (in_data.m11 > in_data.m22)
            br_next = BR_Y;
        else
            br_next = BR_Z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_a_reg <= 1'b0;
        else if (en)
            valid_a_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            br_a_reg <= br_next;
            m_a_reg  <= in_data;
        end
    end

    // Stage B: signed sums per branch
    logic signed [TW-1:0] a00, a11, a22, t_full;
    logic signed [DW-1:0] d1, d2, d3;
    logic signed [DW-1:0] e01, e10, e20, e02, e12, e21;

    always_comb
    begin
        a00 = TW'(m_a_reg.m00);
        a11 = TW'(m_a_reg.m11);
        a22 = TW'(m_a_reg.m22);
        e01 = DW'(m_a_reg.m01);
        e10 = DW'(m_a_reg.m10);
        e20 = DW'(m_a_reg.m20);
        e02 = DW'(m_a_reg.m02);
        e12 = DW'(m_a_reg.m12);
        e21 = DW'(m_a_reg.m21);
        unique case (br_a_reg)
            BR_TRACE:
            begin
                t_full = a00 + a11 + a22 + ONE_Q14;
                d1 = e01 - e10; d2 = e20 - e02; d3 = e12 - e21;
            end
            BR_X:
            begin
                t_full = a00 - a11 - a22 + ONE_Q14;
                d1 = e01 + e10; d2 = e20 + e02; d3 = e12 - e21;
            end
            BR_Y:
            begin
                t_full = a11 - a00 - a22 + ONE_Q14;
                d1 = e01 + e10; d2 = e20 - e02; d3 = e12 + e21;
            end
            default:
            begin
                t_full = a22 - a00 - a11 + ONE_Q14;
                d1 = e01 - e10; d2 = e20 + e02; d3 = e12 + e21;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= valid_a_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data.br  <= br_a_reg;
            out_data.bad <= (t_full <= 0);
            out_data.t   <= t_full[TW-2:0];
            out_data.d1  <= d1;
            out_data.d2  <= d2;
            out_data.d3  <= d3;
        end
    end

endmodule

/* design/rmq_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined restoring square root of t * 2^16, one result bit per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  rmq_pkg::front_t         in_data,
    output logic                    out_valid,
    output rmq_pkg::front_t         out_data,
    output logic [rmq_pkg::RW-1:0]  out_root
);
    import rmq_pkg::*;

    localparam int NS = RW;

    logic                valid_reg [NS+1];
    front_t              meta_reg  [NS+1];
    logic [RADW-1:0]     x_reg     [NS+1];
    logic [RW-1:0]       r_reg     [NS+1];
    logic [RADW+1:0]     rem_reg   [NS+1];

    always_comb
    begin
        valid_reg[0] = in_valid;
        meta_reg[0]  = in_data;
        x_reg[0]     = {1'b0, in_data.t, 16'd0};
        r_reg[0]     = '0;
        rem_reg[0]   = '0;
    end

    // Stage i brings down two radicand bits and decides one root bit.
    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        logic [RADW+1:0] rem_try, trial;
        always_comb
        begin
            rem_try = {rem_reg[i][RADW-1:0], x_reg[i][RADW-1 -: 2]};
            trial   = {{(RADW+2-RW-2){1'b0}}, r_reg[i], 2'b01};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else if (en)
                valid_reg[i+1] <= valid_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                meta_reg[i+1] <= meta_reg[i];
                x_reg[i+1]    <= {x_reg[i][RADW-3:0], 2'b00};
                if (rem_try >= trial)
                begin
                    rem_reg[i+1] <= rem_try - trial;
                    r_reg[i+1]   <= {r_reg[i][RW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1] <= rem_try;
                    r_reg[i+1]   <= {r_reg[i][RW-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = valid_reg[NS];
    assign out_data  = meta_reg[NS];
    assign out_root  = r_reg[NS];

endmodule

/* design/rmq_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div
// Three pipelined restoring dividers, rounding, saturation and output order.
// ----------------------------------------------------------------------------
module rmq_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  rmq_pkg::front_t         in_data,
    input  logic [rmq_pkg::RW-1:0]  in_root,
    output logic                    out_valid,
    output rmq_pkg::quat_t          out_data
);
    import rmq_pkg::*;

    localparam int NS = QW;

    logic            valid_reg [NS+1];
    branch_t         br_reg    [NS+1];
    logic            bad_reg   [NS+1];
    logic [RW-1:0]   root_reg  [NS+1];
    logic [2:0]      neg_reg   [NS+1];
    logic [NUMW-1:0] num_reg   [NS+1][3];
    logic [RW:0]     rem_reg   [NS+1][3];

    logic [DW-1:0] mag [3];
    logic signed [DW-1:0] dd [3];

    always_comb
    begin
        dd[0] = in_data.d1;
        dd[1] = in_data.d2;
        dd[2] = in_data.d3;
        valid_reg[0] = in_valid;
        br_reg[0]    = in_data.br;
        bad_reg[0]   = in_data.bad;
        // Guard against a zero root on a bad item; result is forced to zero.
        root_reg[0]  = in_data.bad ? RW'(1) : in_root;
        for (int j = 0; j < 3; j++)
        begin
            mag[j] = dd[j][DW-1] ? DW'(-dd[j]) : DW'(dd[j]);
            neg_reg[0][j] = dd[j][DW-1];
            num_reg[0][j] = NUMW'({mag[j], 14'd0}) + NUMW'(root_reg[0] >> 1);
            rem_reg[0][j] = '0;
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else if (en)
                valid_reg[i+1] <= valid_reg[i];
        end
        for (genvar j = 0; j < 3; j++)
        begin : g_lane
            logic [RW+1:0] shifted;
            assign shifted = {rem_reg[i][j], num_reg[i][j][NUMW-1]};
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (shifted >= {2'b00, root_reg[i]})
                    begin
                        rem_reg[i+1][j] <= (RW+1)'(shifted - {2'b00, root_reg[i]});
                        num_reg[i+1][j] <= {num_reg[i][j][NUMW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[i+1][j] <= shifted[RW:0];
                        num_reg[i+1][j] <= {num_reg[i][j][NUMW-2:0], 1'b0};
                    end
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                br_reg[i+1]   <= br_reg[i];
                bad_reg[i+1]  <= bad_reg[i];
                root_reg[i+1] <= root_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
            end
        end
    end

    q14_t other [3];
    q14_t main_c;
    q14_t w, x, y, z;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            other[j] = neg_reg[NS][j]
                ? sat16(-(QW+1)'({1'b0, num_reg[NS][j]}))
                : sat16((QW+1)'({1'b0, num_reg[NS][j]}));
        end
        main_c = 16'((RW+1)'(root_reg[NS]) + (RW+1)'(2) >> 2);
        unique case (br_reg[NS])
            BR_TRACE:
            begin
                w = main_c; z = other[0]; y = other[1]; x = other[2];
            end
            BR_X:
            begin
                x = main_c; y = other[0]; z = other[1]; w = other[2];
            end
            BR_Y:
            begin
                y = main_c; x = other[0]; w = other[1]; z = other[2];
            end
            default:
            begin
                z = main_c; w = other[0]; x = other[1]; y = other[2];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= valid_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data.bad_input <= bad_reg[NS];
            out_data.quat_w    <= bad_reg[NS] ? '0 : w;
            out_data.quat_x    <= bad_reg[NS] ? '0 : x;
            out_data.quat_y    <= bad_reg[NS] ? '0 : y;
            out_data.quat_z    <= bad_reg[NS] ? '0 : z;
        end
    end

endmodule

/* design/rotation_matrix_to_quaternion.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix (Q2.14) to quaternion (Q2.14), fully pipelined.
// ----------------------------------------------------------------------------
// Channel   Role   Payload
// mat       sink   m00..m22, signed Q2.14
// quat      source quat_w/x/y/z signed Q2.14, bad_input
//
// One request per cycle while the output is not stalled; each request passes
// the front end, then the bit-per-stage square root and divider pipelines.
// Reset clears all valid bits; data registers are not reset.
// The whole pipeline advances when the output stage is empty or taken;
// a stall freezes every stage, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
    input  logic clk,
    input  logic rst_n,
    rmq_stream_if.sink   mat,
    rmq_stream_if.source quat
);
    import rmq_pkg::*;

    logic   en;
    logic   f_valid, s_valid;
    front_t f_data, s_data;
    logic [RW-1:0] s_root;

    assign en        = !quat.valid || quat.ready;
    assign mat.ready = en;

    rmq_front u_front (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(mat.valid), .in_data(mat.data),
        .out_valid(f_valid), .out_data(f_data)
    );

    rmq_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(f_valid), .in_data(f_data),
        .out_valid(s_valid), .out_data(s_data), .out_root(s_root)
    );

    rmq_div u_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s_valid), .in_data(s_data), .in_root(s_root),
        .out_valid(quat.valid), .out_data(quat.data)
    );

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        quat.valid && quat.data.bad_input |->
            quat.data.quat_w == 0 && quat.data.quat_x == 0 &&
            quat.data.quat_y == 0 && quat.data.quat_z == 0)
        else $error("bad item with nonzero quaternion");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        quat.valid && !quat.ready |=> quat.valid && $stable(quat.data))
        else $error("stalled result changed");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !quat.valid |-> mat.ready)
        else $error("pipeline stalled with empty output");

endmodule
